// File: src/cie_pkg.sv
// types, operation codes and constants shared by the execute core
`timescale 1ns / 1ps

package cie_pkg;

   localparam int OP_W = 6;

   localparam logic [OP_W-1:0] OP_AND     = 6'd0;
   localparam logic [OP_W-1:0] OP_EOR     = 6'd1;
   localparam logic [OP_W-1:0] OP_ORA     = 6'd2;
   localparam logic [OP_W-1:0] OP_BIT     = 6'd3;
   localparam logic [OP_W-1:0] OP_ADC     = 6'd4;
   localparam logic [OP_W-1:0] OP_SBC     = 6'd5;
   localparam logic [OP_W-1:0] OP_CMP     = 6'd6;
   localparam logic [OP_W-1:0] OP_CPX     = 6'd7;
   localparam logic [OP_W-1:0] OP_CPY     = 6'd8;
   localparam logic [OP_W-1:0] OP_LDA     = 6'd9;
   localparam logic [OP_W-1:0] OP_LDX     = 6'd10;
   localparam logic [OP_W-1:0] OP_LDY     = 6'd11;
   localparam logic [OP_W-1:0] OP_STA     = 6'd12;
   localparam logic [OP_W-1:0] OP_STX     = 6'd13;
   localparam logic [OP_W-1:0] OP_STY     = 6'd14;
   localparam logic [OP_W-1:0] OP_INC     = 6'd15;
   localparam logic [OP_W-1:0] OP_DEC     = 6'd16;
   localparam logic [OP_W-1:0] OP_INX     = 6'd17;
   localparam logic [OP_W-1:0] OP_INY     = 6'd18;
   localparam logic [OP_W-1:0] OP_DEX     = 6'd19;
   localparam logic [OP_W-1:0] OP_DEY     = 6'd20;
   localparam logic [OP_W-1:0] OP_ASL_A   = 6'd21;
   localparam logic [OP_W-1:0] OP_ASL_M   = 6'd22;
   localparam logic [OP_W-1:0] OP_LSR_A   = 6'd23;
   localparam logic [OP_W-1:0] OP_LSR_M   = 6'd24;
   localparam logic [OP_W-1:0] OP_ROL_A   = 6'd25;
   localparam logic [OP_W-1:0] OP_ROL_M   = 6'd26;
   localparam logic [OP_W-1:0] OP_ROR_A   = 6'd27;
   localparam logic [OP_W-1:0] OP_ROR_M   = 6'd28;
   localparam logic [OP_W-1:0] OP_TAX     = 6'd29;
   localparam logic [OP_W-1:0] OP_TAY     = 6'd30;
   localparam logic [OP_W-1:0] OP_TXA     = 6'd31;
   localparam logic [OP_W-1:0] OP_TYA     = 6'd32;
   localparam logic [OP_W-1:0] OP_TSX     = 6'd33;
   localparam logic [OP_W-1:0] OP_TXS     = 6'd34;
   localparam logic [OP_W-1:0] OP_PHA     = 6'd35;
   localparam logic [OP_W-1:0] OP_PHP     = 6'd36;
   localparam logic [OP_W-1:0] OP_PLA     = 6'd37;
   localparam logic [OP_W-1:0] OP_PLP     = 6'd38;
   localparam logic [OP_W-1:0] OP_CLC     = 6'd39;
   localparam logic [OP_W-1:0] OP_CLD     = 6'd40;
   localparam logic [OP_W-1:0] OP_CLI     = 6'd41;
   localparam logic [OP_W-1:0] OP_CLV     = 6'd42;
   localparam logic [OP_W-1:0] OP_SEC     = 6'd43;
   localparam logic [OP_W-1:0] OP_SED     = 6'd44;
   localparam logic [OP_W-1:0] OP_SEI     = 6'd45;
   localparam logic [OP_W-1:0] OP_BCC     = 6'd46;
   localparam logic [OP_W-1:0] OP_BCS     = 6'd47;
   localparam logic [OP_W-1:0] OP_BEQ     = 6'd48;
   localparam logic [OP_W-1:0] OP_BMI     = 6'd49;
   localparam logic [OP_W-1:0] OP_BNE     = 6'd50;
   localparam logic [OP_W-1:0] OP_BPL     = 6'd51;
   localparam logic [OP_W-1:0] OP_BVC     = 6'd52;
   localparam logic [OP_W-1:0] OP_BVS     = 6'd53;
   localparam logic [OP_W-1:0] OP_NOP     = 6'd54;

   // status bit positions
   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_B = 4;
   localparam int FLAG_U = 5;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   // stack action codes
   localparam logic [1:0] PP_NONE = 2'd0;
   localparam logic [1:0] PP_PUSH = 2'd1;
   localparam logic [1:0] PP_PULL = 2'd2;

   // shifter kinds
   localparam logic [1:0] SH_ASL = 2'd0;
   localparam logic [1:0] SH_LSR = 2'd1;
   localparam logic [1:0] SH_ROL = 2'd2;
   localparam logic [1:0] SH_ROR = 2'd3;

   localparam logic [7:0] ACC_RST    = 8'h00;
   localparam logic [7:0] X_RST      = 8'h00;
   localparam logic [7:0] Y_RST      = 8'h00;
   localparam logic [7:0] STATUS_RST = 8'h24;
   localparam logic [7:0] SP_RST     = 8'hFD;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 56;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] x_reg;
      logic [7:0] y_reg;
      logic [7:0] status;
      logic [7:0] stack_ptr;
   } regs_type;

   typedef struct packed {
      logic [7:0] write_data;
      logic       write_valid;
      logic [1:0] push_pull;
      logic       branch_taken;
   } side_type;

endpackage

// File: src/cie_execute.sv
// single-pass execute logic: next register state and side results for one operation
`timescale 1ns / 1ps

module cie_execute (
   input  logic [cie_pkg::OP_W-1:0] op,
   input  logic [7:0]               operand,
   input  cie_pkg::regs_type        cur,
   output cie_pkg::regs_type        nxt,
   output cie_pkg::side_type        side
);

   logic [7:0] m_eff;
   logic [8:0] sum;
   logic [7:0] cmp_reg;
   logic [8:0] diff;
   logic [1:0] sh_kind;
   logic [7:0] sh_src;
   logic [7:0] sh_res;
   logic       sh_cout;

   // status with z and n taken from a value
   function automatic logic [7:0] with_nz(input logic [7:0] st, input logic [7:0] v);
      logic [7:0] r;
      r = st;
      r[cie_pkg::FLAG_Z] = (v == 8'h00);
      r[cie_pkg::FLAG_N] = v[7];
      return r;
   endfunction

   // adder shared by adc and sbc, sbc feeds the complement
   assign m_eff = (op == cie_pkg::OP_SBC) ? ~operand : operand;
   assign sum   = {1'b0, cur.acc} + {1'b0, m_eff} + {8'h00, cur.status[cie_pkg::FLAG_C]};

   // comparator shared by cmp, cpx and cpy
   always_comb begin
      case (op)
         cie_pkg::OP_CPX: cmp_reg = cur.x_reg;
         cie_pkg::OP_CPY: cmp_reg = cur.y_reg;
         default:         cmp_reg = cur.acc;
      endcase
   end
   assign diff = {1'b0, cmp_reg} - {1'b0, operand};

   // shifter shared by the accumulator and memory forms
   always_comb begin
      case (op)
         cie_pkg::OP_ASL_A, cie_pkg::OP_ASL_M: sh_kind = cie_pkg::SH_ASL;
         cie_pkg::OP_LSR_A, cie_pkg::OP_LSR_M: sh_kind = cie_pkg::SH_LSR;
         cie_pkg::OP_ROL_A, cie_pkg::OP_ROL_M: sh_kind = cie_pkg::SH_ROL;
         default:                              sh_kind = cie_pkg::SH_ROR;
      endcase
      sh_src = (op == cie_pkg::OP_ASL_A || op == cie_pkg::OP_LSR_A ||
                op == cie_pkg::OP_ROL_A || op == cie_pkg::OP_ROR_A) ? cur.acc : operand;
      case (sh_kind)
         cie_pkg::SH_ASL: begin
            sh_res  = {sh_src[6:0], 1'b0};
            sh_cout = sh_src[7];
         end
         cie_pkg::SH_LSR: begin
            sh_res  = {1'b0, sh_src[7:1]};
            sh_cout = sh_src[0];
         end
         cie_pkg::SH_ROL: begin
            sh_res  = {sh_src[6:0], cur.status[cie_pkg::FLAG_C]};
            sh_cout = sh_src[7];
         end
         default: begin
            sh_res  = {cur.status[cie_pkg::FLAG_C], sh_src[7:1]};
            sh_cout = sh_src[0];
         end
      endcase
   end

   always_comb begin
      nxt  = cur;
      side = '0;
      case (op)
         cie_pkg::OP_AND: begin
            nxt.acc    = cur.acc & operand;
            nxt.status = with_nz(cur.status, cur.acc & operand);
         end
         cie_pkg::OP_EOR: begin
            nxt.acc    = cur.acc ^ operand;
            nxt.status = with_nz(cur.status, cur.acc ^ operand);
         end
         cie_pkg::OP_ORA: begin
            nxt.acc    = cur.acc | operand;
            nxt.status = with_nz(cur.status, cur.acc | operand);
         end
         cie_pkg::OP_BIT: begin
            nxt.status[cie_pkg::FLAG_Z] = ((cur.acc & operand) == 8'h00);
            nxt.status[cie_pkg::FLAG_N] = operand[7];
            nxt.status[cie_pkg::FLAG_V] = operand[6];
         end
         cie_pkg::OP_ADC, cie_pkg::OP_SBC: begin
            nxt.acc    = sum[7:0];
            nxt.status = with_nz(cur.status, sum[7:0]);
            nxt.status[cie_pkg::FLAG_C] = sum[8];
            nxt.status[cie_pkg::FLAG_V] = (m_eff[7] ^ sum[7]) & (sum[7] ^ cur.acc[7]);
         end
         cie_pkg::OP_CMP, cie_pkg::OP_CPX, cie_pkg::OP_CPY: begin
            nxt.status = with_nz(cur.status, diff[7:0]);
            nxt.status[cie_pkg::FLAG_C] = ~diff[8];
         end
         cie_pkg::OP_LDA: begin
            nxt.acc    = operand;
            nxt.status = with_nz(cur.status, operand);
         end
         cie_pkg::OP_LDX: begin
            nxt.x_reg  = operand;
            nxt.status = with_nz(cur.status, operand);
         end
         cie_pkg::OP_LDY: begin
            nxt.y_reg  = operand;
            nxt.status = with_nz(cur.status, operand);
         end
         cie_pkg::OP_STA: begin
            side.write_data  = cur.acc;
            side.write_valid = 1'b1;
         end
         cie_pkg::OP_STX: begin
            side.write_data  = cur.x_reg;
            side.write_valid = 1'b1;
         end
         cie_pkg::OP_STY: begin
            side.write_data  = cur.y_reg;
            side.write_valid = 1'b1;
         end
         cie_pkg::OP_INC: begin
            side.write_data  = operand + 8'd1;
            side.write_valid = 1'b1;
            nxt.status       = with_nz(cur.status, operand + 8'd1);
         end
         cie_pkg::OP_DEC: begin
            side.write_data  = operand - 8'd1;
            side.write_valid = 1'b1;
            nxt.status       = with_nz(cur.status, operand - 8'd1);
         end
         cie_pkg::OP_INX: begin
            nxt.x_reg  = cur.x_reg + 8'd1;
            nxt.status = with_nz(cur.status, cur.x_reg + 8'd1);
         end
         cie_pkg::OP_INY: begin
            nxt.y_reg  = cur.y_reg + 8'd1;
            nxt.status = with_nz(cur.status, cur.y_reg + 8'd1);
         end
         cie_pkg::OP_DEX: begin
            nxt.x_reg  = cur.x_reg - 8'd1;
            nxt.status = with_nz(cur.status, cur.x_reg - 8'd1);
         end
         cie_pkg::OP_DEY: begin
            nxt.y_reg  = cur.y_reg - 8'd1;
            nxt.status = with_nz(cur.status, cur.y_reg - 8'd1);
         end
         cie_pkg::OP_ASL_A, cie_pkg::OP_LSR_A, cie_pkg::OP_ROL_A, cie_pkg::OP_ROR_A: begin
            nxt.acc    = sh_res;
            nxt.status = with_nz(cur.status, sh_res);
            nxt.status[cie_pkg::FLAG_C] = sh_cout;
         end
         cie_pkg::OP_ASL_M, cie_pkg::OP_LSR_M, cie_pkg::OP_ROL_M, cie_pkg::OP_ROR_M: begin
            side.write_data  = sh_res;
            side.write_valid = 1'b1;
            nxt.status       = with_nz(cur.status, sh_res);
            nxt.status[cie_pkg::FLAG_C] = sh_cout;
         end
         cie_pkg::OP_TAX: begin
            nxt.x_reg  = cur.acc;
            nxt.status = with_nz(cur.status, cur.acc);
         end
         cie_pkg::OP_TAY: begin
            nxt.y_reg  = cur.acc;
            nxt.status = with_nz(cur.status, cur.acc);
         end
         cie_pkg::OP_TXA: begin
            nxt.acc    = cur.x_reg;
            nxt.status = with_nz(cur.status, cur.x_reg);
         end
         cie_pkg::OP_TYA: begin
            nxt.acc    = cur.y_reg;
            nxt.status = with_nz(cur.status, cur.y_reg);
         end
         cie_pkg::OP_TSX: begin
            nxt.x_reg  = cur.stack_ptr;
            nxt.status = with_nz(cur.status, cur.stack_ptr);
         end
         cie_pkg::OP_TXS: begin
            nxt.stack_ptr = cur.x_reg;
         end
         cie_pkg::OP_PHA: begin
            side.write_data  = cur.acc;
            side.write_valid = 1'b1;
            side.push_pull   = cie_pkg::PP_PUSH;
            nxt.stack_ptr    = cur.stack_ptr - 8'd1;
         end
         cie_pkg::OP_PHP: begin
            // pushed copy carries b and u set
            side.write_data  = cur.status | 8'h30;
            side.write_valid = 1'b1;
            side.push_pull   = cie_pkg::PP_PUSH;
            nxt.stack_ptr    = cur.stack_ptr - 8'd1;
         end
         cie_pkg::OP_PLA: begin
            side.push_pull = cie_pkg::PP_PULL;
            nxt.stack_ptr  = cur.stack_ptr + 8'd1;
            nxt.acc        = operand;
            nxt.status     = with_nz(cur.status, operand);
         end
         cie_pkg::OP_PLP: begin
            side.push_pull = cie_pkg::PP_PULL;
            nxt.stack_ptr  = cur.stack_ptr + 8'd1;
            nxt.status     = operand;
            nxt.status[cie_pkg::FLAG_B] = 1'b0;
            nxt.status[cie_pkg::FLAG_U] = 1'b1;
         end
         cie_pkg::OP_CLC: nxt.status[cie_pkg::FLAG_C] = 1'b0;
         cie_pkg::OP_CLD: nxt.status[cie_pkg::FLAG_D] = 1'b0;
         cie_pkg::OP_CLI: nxt.status[cie_pkg::FLAG_I] = 1'b0;
         cie_pkg::OP_CLV: nxt.status[cie_pkg::FLAG_V] = 1'b0;
         cie_pkg::OP_SEC: nxt.status[cie_pkg::FLAG_C] = 1'b1;
         cie_pkg::OP_SED: nxt.status[cie_pkg::FLAG_D] = 1'b1;
         cie_pkg::OP_SEI: nxt.status[cie_pkg::FLAG_I] = 1'b1;
         cie_pkg::OP_BCC: side.branch_taken = ~cur.status[cie_pkg::FLAG_C];
         cie_pkg::OP_BCS: side.branch_taken =  cur.status[cie_pkg::FLAG_C];
         cie_pkg::OP_BEQ: side.branch_taken =  cur.status[cie_pkg::FLAG_Z];
         cie_pkg::OP_BMI: side.branch_taken =  cur.status[cie_pkg::FLAG_N];
         cie_pkg::OP_BNE: side.branch_taken = ~cur.status[cie_pkg::FLAG_Z];
         cie_pkg::OP_BPL: side.branch_taken = ~cur.status[cie_pkg::FLAG_N];
         cie_pkg::OP_BVC: side.branch_taken = ~cur.status[cie_pkg::FLAG_V];
         cie_pkg::OP_BVS: side.branch_taken =  cur.status[cie_pkg::FLAG_V];
         // nop and unassigned codes leave everything alone
         default: ;
      endcase
   end

endmodule

// File: src/cie_arch_regs.sv
// architectural registers a, x, y, status and stack pointer
`timescale 1ns / 1ps

module cie_arch_regs (
   input  logic              clock,
   input  logic              reset,
   input  logic              commit,
   input  cie_pkg::regs_type regs_in,
   output cie_pkg::regs_type regs
);

   cie_pkg::regs_type regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.acc       <= cie_pkg::ACC_RST;
         regs_ff.x_reg     <= cie_pkg::X_RST;
         regs_ff.y_reg     <= cie_pkg::Y_RST;
         regs_ff.status    <= cie_pkg::STATUS_RST;
         regs_ff.stack_ptr <= cie_pkg::SP_RST;
      end else if (commit) begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

// File: src/cpu8_instruction_execute_core.sv
// top level: input register, execute stage and result register of the 6502 execute core
`timescale 1ns / 1ps

// One decoded 6502 operation per beat, with its operand or popped stack byte. A beat is
// taken into an input register, executed against the a, x, y, status and stack pointer
// registers, and presented from a result register; a new beat is taken every cycle while
// the result side keeps up. The execute stage, which updates the registers as each
// operation leaves the input register, sets that rate; a following operation always sees
// the state left by the one before it. Binary arithmetic only; the d flag is stored but
// does not affect adc or sbc.
module cpu8_instruction_execute_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // op [5:0], operand [13:6], zero [15:14]
   input  logic [cie_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // write_data [7:0], write_valid [8], push_pull [10:9], branch_taken [11],
   // acc_out [19:12], x_out [27:20], y_out [35:28], status_out [43:36],
   // stack_ptr_out [51:44], zero [55:52]
   output logic [cie_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   logic                        req_valid_ff;
   logic [cie_pkg::OP_W-1:0]    req_op_ff;
   logic [7:0]                  req_operand_ff;
   logic                        rsp_valid_ff;
   logic [cie_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [cie_pkg::RSP_DATA_W-1:0] rsp_data_in;
   logic                        advance;
   cie_pkg::regs_type           cur_regs;
   cie_pkg::regs_type           nxt_regs;
   cie_pkg::side_type           side;

   // the execute stage moves when the result register is empty or being drained
   assign advance    = req_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~req_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_op_ff      <= req_tdata[5:0];
         req_operand_ff <= req_tdata[13:6];
      end
   end

   cie_execute u_execute (
      .op      (req_op_ff),
      .operand (req_operand_ff),
      .cur     (cur_regs),
      .nxt     (nxt_regs),
      .side    (side)
   );

   cie_arch_regs u_arch_regs (
      .clock   (clock),
      .reset   (reset),
      .commit  (advance),
      .regs_in (nxt_regs),
      .regs    (cur_regs)
   );

   assign rsp_data_in = {4'h0, nxt_regs.stack_ptr, nxt_regs.status, nxt_regs.y_reg,
                         nxt_regs.x_reg, nxt_regs.acc, side.branch_taken, side.push_pull,
                         side.write_valid, side.write_data};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // u is never cleared once reset has set it
   a_u_flag_set: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[36 + cie_pkg::FLAG_U])
      else $error("u flag clear in result");

   a_pp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[10:9] != 2'd3))
      else $error("illegal stack action code");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[8]) |-> (rsp_tdata[7:0] == 8'h00))
      else $error("write data set without a write");

   // a push leaves the stack pointer one lower, a pull one higher
   a_push_sp: assert property (@(posedge clock) disable iff (reset)
      (advance && side.push_pull == cie_pkg::PP_PUSH)
         |=> (cur_regs.stack_ptr == $past(cur_regs.stack_ptr) - 8'd1))
      else $error("stack pointer not decremented on push");

   a_pull_sp: assert property (@(posedge clock) disable iff (reset)
      (advance && side.push_pull == cie_pkg::PP_PULL)
         |=> (cur_regs.stack_ptr == $past(cur_regs.stack_ptr) + 8'd1))
      else $error("stack pointer not incremented on pull");

   // registers only change when an operation leaves the input register
   a_hold_regs: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(cur_regs))
      else $error("registers changed without an operation");

endmodule

// File: tb/sv/cpu8_instruction_execute_core_tb.sv
// self-checking testbench for the 6502 execute core: directed and random operation streams
`timescale 1ns / 1ps

module cpu8_instruction_execute_core_tb;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_BEATS  = 1800;
   localparam int MAX_REPORTS   = 10;

   // same bit layout as rsp_tdata, lowest field last
   typedef struct packed {
      logic [3:0] pad;
      logic [7:0] stack_ptr;
      logic [7:0] status;
      logic [7:0] y_reg;
      logic [7:0] x_reg;
      logic [7:0] acc;
      logic       branch_taken;
      logic [1:0] push_pull;
      logic       write_valid;
      logic [7:0] write_data;
   } exec_beat_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [cie_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [cie_pkg::RSP_DATA_W-1:0] rsp_tdata;

   cpu8_instruction_execute_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // register file as the core should hold it
   logic [7:0] cpu_acc = cie_pkg::ACC_RST;
   logic [7:0] cpu_x   = cie_pkg::X_RST;
   logic [7:0] cpu_y   = cie_pkg::Y_RST;
   logic [7:0] cpu_st  = cie_pkg::STATUS_RST;
   logic [7:0] cpu_sp  = cie_pkg::SP_RST;

   exec_beat_type retired_q[$];
   int            fail_count = 0;
   int            cycle_count = 0;
   int            beats_sent = 0;
   int            burst_left = 0;
   bit            valid_held = 1'b0;

   function automatic void set_nz(input logic [7:0] v);
      cpu_st[cie_pkg::FLAG_Z] = (v == 8'h00);
      cpu_st[cie_pkg::FLAG_N] = v[7];
   endfunction

   function automatic void add_with_carry(input logic [7:0] m);
      logic [8:0] sum;
      logic [7:0] r;
      sum = {1'b0, cpu_acc} + {1'b0, m} + {8'h00, cpu_st[cie_pkg::FLAG_C]};
      r = sum[7:0];
      cpu_st[cie_pkg::FLAG_C] = sum[8];
      cpu_st[cie_pkg::FLAG_V] = (m[7] ^ r[7]) & (r[7] ^ cpu_acc[7]);
      cpu_acc = r;
      set_nz(r);
   endfunction

   function automatic void compare_reg(input logic [7:0] r, input logic [7:0] m);
      cpu_st[cie_pkg::FLAG_C] = (m <= r);
      set_nz(r - m);
   endfunction

   function automatic logic [7:0] shift_byte(input logic [1:0] kind, input logic [7:0] v);
      logic       cin;
      logic [7:0] r;
      cin = cpu_st[cie_pkg::FLAG_C];
      if (kind == cie_pkg::SH_ASL || kind == cie_pkg::SH_ROL) begin
         cpu_st[cie_pkg::FLAG_C] = v[7];
         r = {v[6:0], (kind == cie_pkg::SH_ROL) ? cin : 1'b0};
      end else begin
         cpu_st[cie_pkg::FLAG_C] = v[0];
         r = {(kind == cie_pkg::SH_ROR) ? cin : 1'b0, v[7:1]};
      end
      set_nz(r);
      return r;
   endfunction

   // advance the register file by one operation and give the beat it retires
   function automatic exec_beat_type retire_op(input logic [5:0] op, input logic [7:0] m);
      exec_beat_type b;
      logic [7:0]    pushed;
      b = '0;
      case (op)
         cie_pkg::OP_AND: begin cpu_acc = cpu_acc & m; set_nz(cpu_acc); end
         cie_pkg::OP_EOR: begin cpu_acc = cpu_acc ^ m; set_nz(cpu_acc); end
         cie_pkg::OP_ORA: begin cpu_acc = cpu_acc | m; set_nz(cpu_acc); end
         cie_pkg::OP_BIT: begin
            cpu_st[cie_pkg::FLAG_Z] = ((cpu_acc & m) == 8'h00);
            cpu_st[cie_pkg::FLAG_N] = m[7];
            cpu_st[cie_pkg::FLAG_V] = m[6];
         end
         cie_pkg::OP_ADC: add_with_carry(m);
         cie_pkg::OP_SBC: add_with_carry(~m);
         cie_pkg::OP_CMP: compare_reg(cpu_acc, m);
         cie_pkg::OP_CPX: compare_reg(cpu_x, m);
         cie_pkg::OP_CPY: compare_reg(cpu_y, m);
         cie_pkg::OP_LDA: begin cpu_acc = m; set_nz(cpu_acc); end
         cie_pkg::OP_LDX: begin cpu_x = m; set_nz(cpu_x); end
         cie_pkg::OP_LDY: begin cpu_y = m; set_nz(cpu_y); end
         cie_pkg::OP_STA: begin b.write_data = cpu_acc; b.write_valid = 1'b1; end
         cie_pkg::OP_STX: begin b.write_data = cpu_x; b.write_valid = 1'b1; end
         cie_pkg::OP_STY: begin b.write_data = cpu_y; b.write_valid = 1'b1; end
         cie_pkg::OP_INC: begin
            b.write_data  = m + 8'd1;
            b.write_valid = 1'b1;
            set_nz(b.write_data);
         end
         cie_pkg::OP_DEC: begin
            b.write_data  = m - 8'd1;
            b.write_valid = 1'b1;
            set_nz(b.write_data);
         end
         cie_pkg::OP_INX: begin cpu_x = cpu_x + 8'd1; set_nz(cpu_x); end
         cie_pkg::OP_INY: begin cpu_y = cpu_y + 8'd1; set_nz(cpu_y); end
         cie_pkg::OP_DEX: begin cpu_x = cpu_x - 8'd1; set_nz(cpu_x); end
         cie_pkg::OP_DEY: begin cpu_y = cpu_y - 8'd1; set_nz(cpu_y); end
         cie_pkg::OP_ASL_A: cpu_acc = shift_byte(cie_pkg::SH_ASL, cpu_acc);
         cie_pkg::OP_LSR_A: cpu_acc = shift_byte(cie_pkg::SH_LSR, cpu_acc);
         cie_pkg::OP_ROL_A: cpu_acc = shift_byte(cie_pkg::SH_ROL, cpu_acc);
         cie_pkg::OP_ROR_A: cpu_acc = shift_byte(cie_pkg::SH_ROR, cpu_acc);
         cie_pkg::OP_ASL_M: begin
            b.write_data  = shift_byte(cie_pkg::SH_ASL, m);
            b.write_valid = 1'b1;
         end
         cie_pkg::OP_LSR_M: begin
            b.write_data  = shift_byte(cie_pkg::SH_LSR, m);
            b.write_valid = 1'b1;
         end
         cie_pkg::OP_ROL_M: begin
            b.write_data  = shift_byte(cie_pkg::SH_ROL, m);
            b.write_valid = 1'b1;
         end
         cie_pkg::OP_ROR_M: begin
            b.write_data  = shift_byte(cie_pkg::SH_ROR, m);
            b.write_valid = 1'b1;
         end
         cie_pkg::OP_TAX: begin cpu_x = cpu_acc; set_nz(cpu_x); end
         cie_pkg::OP_TAY: begin cpu_y = cpu_acc; set_nz(cpu_y); end
         cie_pkg::OP_TXA: begin cpu_acc = cpu_x; set_nz(cpu_acc); end
         cie_pkg::OP_TYA: begin cpu_acc = cpu_y; set_nz(cpu_acc); end
         cie_pkg::OP_TSX: begin cpu_x = cpu_sp; set_nz(cpu_x); end
         cie_pkg::OP_TXS: cpu_sp = cpu_x;
         cie_pkg::OP_PHA, cie_pkg::OP_PHP: begin
            pushed = cpu_st;
            pushed[cie_pkg::FLAG_B] = 1'b1;
            pushed[cie_pkg::FLAG_U] = 1'b1;
            b.write_data  = (op == cie_pkg::OP_PHA) ? cpu_acc : pushed;
            b.write_valid = 1'b1;
            b.push_pull   = cie_pkg::PP_PUSH;
            cpu_sp = cpu_sp - 8'd1;
         end
         cie_pkg::OP_PLA: begin
            b.push_pull = cie_pkg::PP_PULL;
            cpu_sp  = cpu_sp + 8'd1;
            cpu_acc = m;
            set_nz(cpu_acc);
         end
         cie_pkg::OP_PLP: begin
            b.push_pull = cie_pkg::PP_PULL;
            cpu_sp = cpu_sp + 8'd1;
            cpu_st = m;
            cpu_st[cie_pkg::FLAG_B] = 1'b0;
            cpu_st[cie_pkg::FLAG_U] = 1'b1;
         end
         cie_pkg::OP_CLC: cpu_st[cie_pkg::FLAG_C] = 1'b0;
         cie_pkg::OP_CLD: cpu_st[cie_pkg::FLAG_D] = 1'b0;
         cie_pkg::OP_CLI: cpu_st[cie_pkg::FLAG_I] = 1'b0;
         cie_pkg::OP_CLV: cpu_st[cie_pkg::FLAG_V] = 1'b0;
         cie_pkg::OP_SEC: cpu_st[cie_pkg::FLAG_C] = 1'b1;
         cie_pkg::OP_SED: cpu_st[cie_pkg::FLAG_D] = 1'b1;
         cie_pkg::OP_SEI: cpu_st[cie_pkg::FLAG_I] = 1'b1;
         cie_pkg::OP_BCC: b.branch_taken = !cpu_st[cie_pkg::FLAG_C];
         cie_pkg::OP_BCS: b.branch_taken = cpu_st[cie_pkg::FLAG_C];
         cie_pkg::OP_BEQ: b.branch_taken = cpu_st[cie_pkg::FLAG_Z];
         cie_pkg::OP_BMI: b.branch_taken = cpu_st[cie_pkg::FLAG_N];
         cie_pkg::OP_BNE: b.branch_taken = !cpu_st[cie_pkg::FLAG_Z];
         cie_pkg::OP_BPL: b.branch_taken = !cpu_st[cie_pkg::FLAG_N];
         cie_pkg::OP_BVC: b.branch_taken = !cpu_st[cie_pkg::FLAG_V];
         cie_pkg::OP_BVS: b.branch_taken = cpu_st[cie_pkg::FLAG_V];
         default: ;
      endcase
      b.acc       = cpu_acc;
      b.x_reg     = cpu_x;
      b.y_reg     = cpu_y;
      b.status    = cpu_st;
      b.stack_ptr = cpu_sp;
      return b;
   endfunction

   function automatic void note_failure(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("mismatch %s: expected %h, got %h", what, want, got);
   endfunction

   function automatic void check_field(input string what, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got)
         note_failure(what, want, got);
   endfunction

   // result side: compare every accepted beat with the oldest retired operation
   always @(posedge clock) begin
      exec_beat_type want;
      exec_beat_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (retired_q.size() == 0) begin
            note_failure("unexpected beat, write_data", 8'h00, got.write_data);
         end else begin
            want = retired_q.pop_front();
            check_field("write_data", want.write_data, got.write_data);
            check_field("write_valid", 8'(want.write_valid), 8'(got.write_valid));
            check_field("push_pull", 8'(want.push_pull), 8'(got.push_pull));
            check_field("branch_taken", 8'(want.branch_taken), 8'(got.branch_taken));
            check_field("acc_out", want.acc, got.acc);
            check_field("x_out", want.x_reg, got.x_reg);
            check_field("y_out", want.y_reg, got.y_reg);
            check_field("status_out", want.status, got.status);
            check_field("stack_ptr_out", want.stack_ptr, got.stack_ptr);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side stalls: runs of always ready, one in four, coin toss and long stalls
   initial begin
      int mode;
      int span;
      @(negedge reset);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 80);
         for (int i = 0; i < span; i++) begin
            @(posedge clock);
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= (i % 4 != 3);
               2: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= (i % 20 >= 15);
            endcase
         end
      end
   end

   task automatic release_req();
      if (valid_held) begin
         req_tvalid <= 1'b0;
         valid_held = 1'b0;
      end
   endtask

   // one beat in, then the burst and gap pattern of the sender
   task automatic send_op(input logic [5:0] op, input logic [7:0] operand);
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, operand, op};
      valid_held = 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      retired_q.push_back(retire_op(op, operand));
      beats_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12);
         if ($urandom_range(0, 2) != 0) begin
            release_req();
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   task automatic drain_results();
      release_req();
      do
         @(posedge clock);
      while (retired_q.size() != 0);
   endtask

   function automatic logic [7:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic test_reset_and_spare_codes();
      send_op(cie_pkg::OP_NOP, 8'h00);
      send_op(6'd63, 8'hFF);
      send_op(6'd55, 8'h00);
   endtask

   task automatic test_add_subtract();
      send_op(cie_pkg::OP_LDA, 8'h7F);
      send_op(cie_pkg::OP_ADC, 8'h01);    // signed overflow into n
      send_op(cie_pkg::OP_ADC, 8'h80);    // carry out, overflow and zero together
      send_op(cie_pkg::OP_SBC, 8'h00);
      send_op(cie_pkg::OP_SED, 8'h00);
      send_op(cie_pkg::OP_SBC, 8'hFF);    // decimal flag leaves binary sum alone
   endtask

   task automatic test_compare_and_bit();
      send_op(cie_pkg::OP_CMP, 8'h01);
      send_op(cie_pkg::OP_LDX, 8'hFF);
      send_op(cie_pkg::OP_CPX, 8'h00);
      send_op(cie_pkg::OP_CPX, 8'hFF);
      send_op(cie_pkg::OP_LDA, 8'h0F);
      send_op(cie_pkg::OP_BIT, 8'hF0);    // n and v from the operand, z from the and
   endtask

   task automatic test_shift_and_step();
      send_op(cie_pkg::OP_SEC, 8'h00);
      send_op(cie_pkg::OP_ROR_A, 8'h00);  // carry lands in bit 7
      send_op(cie_pkg::OP_ROL_M, 8'h80);
      send_op(cie_pkg::OP_CLC, 8'h00);
      send_op(cie_pkg::OP_ROL_M, 8'h80);  // memory rotate to zero
      send_op(cie_pkg::OP_LDY, 8'hFF);
      send_op(cie_pkg::OP_INY, 8'h00);    // flags from the new y
      send_op(cie_pkg::OP_DEC, 8'h00);
   endtask

   task automatic test_stack_wrap();
      send_op(cie_pkg::OP_LDX, 8'h00);
      send_op(cie_pkg::OP_TXS, 8'h00);
      send_op(cie_pkg::OP_PHP, 8'h00);    // pointer wraps below zero
      send_op(cie_pkg::OP_PLP, 8'hFF);    // b dropped, u kept
      send_op(cie_pkg::OP_PLA, 8'h80);
   endtask

   task automatic test_every_code();
      for (int code = 0; code < 64; code++)
         send_op(6'(code), pick_operand());
   endtask

   // short instruction runs with random content, some noise among them
   task automatic test_random_stream(input int count);
      int target;
      target = beats_sent + count;
      while (beats_sent < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               if ($urandom_range(0, 9) == 0)
                  send_op(6'($urandom_range(55, 63)), pick_operand());
               else
                  send_op(6'($urandom_range(cie_pkg::OP_AND, cie_pkg::OP_NOP)),
                          pick_operand());
            end
            5, 6: begin
               send_op(6'($urandom_range(cie_pkg::OP_AND, cie_pkg::OP_SEI)), pick_operand());
               send_op(6'($urandom_range(cie_pkg::OP_BCC, cie_pkg::OP_BVS)), pick_operand());
            end
            7: begin
               send_op(6'($urandom_range(cie_pkg::OP_PHA, cie_pkg::OP_PHP)), pick_operand());
               send_op(6'($urandom_range(cie_pkg::OP_PLA, cie_pkg::OP_PLP)), pick_operand());
            end
            8: begin
               send_op(6'($urandom_range(cie_pkg::OP_LDA, cie_pkg::OP_LDY)), pick_operand());
               send_op(6'($urandom_range(cie_pkg::OP_AND, cie_pkg::OP_CPY)), pick_operand());
            end
            default: begin
               send_op(6'($urandom_range(cie_pkg::OP_TAX, cie_pkg::OP_TXS)), pick_operand());
               send_op(6'($urandom_range(cie_pkg::OP_INX, cie_pkg::OP_DEY)), pick_operand());
            end
         endcase
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_and_spare_codes();
      test_add_subtract();
      test_compare_and_bit();
      test_shift_and_step();
      test_stack_wrap();
      test_every_code();
      test_random_stream(RANDOM_BEATS / 2);
      // hold off the sender until the result side has caught up
      drain_results();
      test_random_stream(RANDOM_BEATS / 2);
      drain_results();
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: files.f
src/cie_pkg.sv
src/cie_execute.sv
src/cie_arch_regs.sv
src/cpu8_instruction_execute_core.sv
tb/sv/cpu8_instruction_execute_core_tb.sv
